[rtl/wsmv_pkg.sv]
// shared types and constants of the weighted sparse matrix-vector core
// no dependencies
package wsmv_pkg;

    localparam logic [2:0] REQ_LOAD_ENTRY = 3'd0;
    localparam logic [2:0] REQ_LOAD_VEC   = 3'd1;
    localparam logic [2:0] REQ_COMPUTE    = 3'd2;
    localparam logic [2:0] REQ_READ       = 3'd3;
    localparam logic [2:0] REQ_CLEAR      = 3'd4;

    localparam logic [1:0] REG_DIRECTION  = 2'd0;
    localparam logic [1:0] REG_NUM_COMP   = 2'd1;
    localparam logic [1:0] REG_NUM_ROWS   = 2'd2;
    localparam logic [1:0] REG_NUM_COLS   = 2'd3;

    localparam logic signed [64:0] Q_MAX = 65'sd2147483647;
    localparam logic signed [64:0] Q_MIN = -65'sd2147483648;

    typedef struct packed {
        logic       direction;
        logic [2:0] num_comp;
        logic [8:0] num_rows;
        logic [8:0] num_cols;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  row;
        logic [7:0]  col;
        logic [31:0] coeff;
        logic [31:0] deno_fwd;
        logic [31:0] deno_rev;
    } entry_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_ENT_RD,
        ST_ENT_CHK,
        ST_VEC_RD,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_ACC_RD,
        ST_ACC_WR
    } state_t;

endpackage

[rtl/wsmv_div.sv]
// radix-2 signed divider, 64-bit dividend by 32-bit divisor, truncating toward zero
// depends on nothing; one quotient bit per cycle, then a sign fix step
module wsmv_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] dividend,
    input  logic signed [31:0] divisor,
    output logic               done,
    output logic signed [63:0] quotient
);
    logic        run_reg;
    logic        fix_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [32:0] rem_reg;
    logic [63:0] dvd_reg;
    logic [31:0] dvs_reg;
    logic        neg_reg;
    logic [63:0] quo_reg;
    logic [32:0] rem_sh;
    logic        ge;

    assign rem_sh = {rem_reg[31:0], dvd_reg[63]};
    assign ge     = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    run_reg <= 1'b0;
                    fix_reg <= 1'b1;
                end
            end
            else if (fix_reg)
            begin
                fix_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend[63] ? 64'(-dividend) : dividend;
            dvs_reg <= divisor[31] ? 32'(-divisor) : divisor;
            neg_reg <= dividend[63] ^ divisor[31];
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
            dvd_reg <= {dvd_reg[62:0], ge};
        end
        else if (fix_reg)
        begin
            quo_reg <= neg_reg ? 64'(-dvd_reg) : dvd_reg;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

[rtl/wsmv_cfg.sv]
// apb configuration registers with clamping of the counts
// depends on wsmv_pkg
module wsmv_cfg #(
    parameter int MAX_ROWS       = 256,
    parameter int MAX_COLS       = 256,
    parameter int MAX_COMPONENTS = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output wsmv_pkg::cfg_t    cfg
);
    import wsmv_pkg::*;

    logic       dir_reg;
    logic [2:0] nc_reg;
    logic [8:0] nr_reg;
    logic [8:0] ncol_reg;
    logic       wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg  <= 1'b0;
            nc_reg   <= 3'd1;
            nr_reg   <= 9'd256;
            ncol_reg <= 9'd256;
        end
        else if (wr)
        begin
            case (paddr[3:2])
                REG_DIRECTION: dir_reg  <= pwdata[0];
                REG_NUM_COMP:  nc_reg   <= pwdata[2:0];
                REG_NUM_ROWS:  nr_reg   <= pwdata[8:0];
                REG_NUM_COLS:  ncol_reg <= pwdata[8:0];
                default:       dir_reg  <= dir_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_DIRECTION: prdata = {31'd0, dir_reg};
            REG_NUM_COMP:  prdata = {29'd0, nc_reg};
            REG_NUM_ROWS:  prdata = {23'd0, nr_reg};
            REG_NUM_COLS:  prdata = {23'd0, ncol_reg};
            default:       prdata = '0;
        endcase
    end

    // counts clamped to 1..max
    always_comb
    begin
        cfg.direction = dir_reg;
        if (nc_reg == 3'd0)
            cfg.num_comp = 3'd1;
        else if (32'(nc_reg) > MAX_COMPONENTS)
            cfg.num_comp = 3'(MAX_COMPONENTS);
        else
            cfg.num_comp = nc_reg;
        if (nr_reg == 9'd0)
            cfg.num_rows = 9'd1;
        else if (32'(nr_reg) > MAX_ROWS)
            cfg.num_rows = 9'(MAX_ROWS);
        else
            cfg.num_rows = nr_reg;
        if (ncol_reg == 9'd0)
            cfg.num_cols = 9'd1;
        else if (32'(ncol_reg) > MAX_COLS)
            cfg.num_cols = 9'(MAX_COLS);
        else
            cfg.num_cols = ncol_reg;
    end
endmodule

[rtl/weighted_sparse_matvec_core.sv]
// top level: entry, vector and accumulator memories, compute sequencer
// depends on wsmv_pkg, wsmv_cfg, wsmv_div
//
// Commands (load entry, load vector, compute, read result, clear matrix) are taken when start is
// high and busy is low. Loads, reads and clears are handled without leaving idle and stream back
// to back. A read answers on the cycle after it is taken with done high for exactly that one
// cycle; the receiver cannot stall, so it must capture result_value and the flags then. After
// reset the block is busy for a sweep over all VEC_DEPTH slots (1024 with default parameters)
// while it zeroes the vector and accumulator memories; configuration writes are taken meanwhile.
// A compute is busy while it clears the accumulator memory, then per stored entry reads and
// checks it, and for each used component does a vector read, a multiply, a 64-step bit-serial
// divide with a sign fix, an accumulator read and a write back. Skipped entries (out of range,
// zero denominator) end after the check.
module weighted_sparse_matvec_core #(
    parameter int MAX_ENTRIES    = 1024,
    parameter int MAX_ROWS       = 256,
    parameter int MAX_COLS       = 256,
    parameter int MAX_COMPONENTS = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    // command side
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         req_type,
    input  logic [7:0]         entry_row,
    input  logic [7:0]         entry_col,
    input  logic signed [31:0] coeff,
    input  logic signed [31:0] deno_fwd,
    input  logic signed [31:0] deno_rev,
    input  logic [7:0]         vec_index,
    input  logic [1:0]         component,
    input  logic signed [31:0] vec_value,
    // result side
    output logic               done,
    output logic signed [31:0] result_value,
    output logic               saturated,
    output logic               divided_by_zero,
    output logic               store_overflowed,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import wsmv_pkg::*;

    localparam int VEC_ELEMS = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int VEC_DEPTH = VEC_ELEMS * MAX_COMPONENTS;
    localparam int SLOT_W    = $clog2(VEC_DEPTH);
    localparam int EA_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);

    cfg_t   cfg;
    state_t state_reg, state_next;

    // control registers
    logic [CNT_W-1:0]  entry_count_reg;
    logic [CNT_W-1:0]  e_reg;
    logic [SLOT_W-1:0] clr_reg;
    logic [2:0]        c_reg;
    logic              sat_reg, divz_reg, full_reg;
    logic              rd_pend_reg;
    // payload registers
    logic              slot_ok_reg;
    logic              sat_out_reg, divz_out_reg, full_out_reg;
    logic [7:0]        src_reg, dst_reg;
    logic signed [31:0] w_reg, d_reg;
    logic signed [63:0] prod_reg;

    // memories
    entry_t      ent_mem [MAX_ENTRIES];
    logic [31:0] vec_mem [VEC_DEPTH];
    logic [31:0] acc_mem [VEC_DEPTH];
    entry_t      ent_rdata;
    logic [31:0] vec_rdata, acc_rdata;

    logic              ent_we;
    logic              vec_we, acc_we;
    logic [SLOT_W-1:0] vec_waddr, vec_raddr, acc_waddr, acc_raddr;
    logic [31:0]       vec_wdata, acc_wdata;
    logic              div_start, div_done;
    logic signed [63:0] quotient;

    logic              accept;
    logic              in_slot_ok;
    logic [SLOT_W-1:0] in_slot, src_slot, dst_slot;
    logic              clr_last;
    logic              ent_skip, ent_zero;
    logic [31:0]       ent_deno;
    logic signed [64:0] sum;
    logic [31:0]       sum_sat;
    logic              sum_ovf;
    logic              comp_last;

    wsmv_cfg #(
        .MAX_ROWS       (MAX_ROWS),
        .MAX_COLS       (MAX_COLS),
        .MAX_COMPONENTS (MAX_COMPONENTS)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wsmv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (d_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign busy   = state_reg != ST_IDLE;
    assign accept = start && !busy;

    // element slot of the command's index and component
    assign in_slot_ok = (32'(vec_index) < VEC_ELEMS) && (32'(component) < MAX_COMPONENTS);
    assign in_slot    = SLOT_W'(32'(vec_index) * MAX_COMPONENTS + 32'(component));
    assign src_slot   = SLOT_W'(32'(src_reg) * MAX_COMPONENTS + 32'(c_reg));
    assign dst_slot   = SLOT_W'(32'(dst_reg) * MAX_COMPONENTS + 32'(c_reg));
    assign clr_last   = clr_reg == SLOT_W'(VEC_DEPTH - 1);
    assign comp_last  = (c_reg + 3'd1) == cfg.num_comp;

    // entry check: out of range is skipped silently, zero denominator is flagged and skipped
    assign ent_deno = cfg.direction ? ent_rdata.deno_rev : ent_rdata.deno_fwd;
    assign ent_skip = ({1'b0, ent_rdata.row} >= cfg.num_rows) ||
                      ({1'b0, ent_rdata.col} >= cfg.num_cols);
    assign ent_zero = ent_deno == 32'd0;

    // saturating accumulate of the quotient
    assign sum     = 65'($signed(acc_rdata)) + 65'(quotient);
    assign sum_ovf = (sum > Q_MAX) || (sum < Q_MIN);
    always_comb
    begin
        if (sum > Q_MAX)
            sum_sat = 32'h7fff_ffff;
        else if (sum < Q_MIN)
            sum_sat = 32'h8000_0000;
        else
            sum_sat = sum[31:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
                if (clr_last)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (accept && req_type == REQ_COMPUTE)
                    state_next = ST_CLEAR;
            ST_CLEAR:
                if (clr_last)
                    state_next = ST_ENT_RD;
            ST_ENT_RD:
                state_next = (e_reg == entry_count_reg) ? ST_IDLE : ST_ENT_CHK;
            ST_ENT_CHK:
                state_next = (ent_skip || ent_zero) ? ST_ENT_RD : ST_VEC_RD;
            ST_VEC_RD:
                state_next = ST_MUL;
            ST_MUL:
                state_next = ST_DIV_GO;
            ST_DIV_GO:
                state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
                if (div_done)
                    state_next = ST_ACC_RD;
            ST_ACC_RD:
                state_next = ST_ACC_WR;
            ST_ACC_WR:
                state_next = comp_last ? ST_ENT_RD : ST_VEC_RD;
            default:
                state_next = ST_INIT;
        endcase
    end

    // memory and divider controls
    always_comb
    begin
        ent_we    = 1'b0;
        vec_we    = 1'b0;
        vec_waddr = in_slot;
        vec_wdata = vec_value;
        vec_raddr = src_slot;
        acc_we    = 1'b0;
        acc_waddr = clr_reg;
        acc_wdata = '0;
        acc_raddr = in_slot;
        div_start = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                vec_we    = 1'b1;
                vec_waddr = clr_reg;
                vec_wdata = '0;
                acc_we    = 1'b1;
            end
            ST_IDLE:
            begin
                ent_we = accept && req_type == REQ_LOAD_ENTRY &&
                         entry_count_reg != CNT_W'(MAX_ENTRIES);
                vec_we = accept && req_type == REQ_LOAD_VEC && in_slot_ok;
            end
            ST_CLEAR:
                acc_we = 1'b1;
            ST_DIV_GO:
                div_start = 1'b1;
            ST_ACC_RD:
                acc_raddr = dst_slot;
            ST_ACC_WR:
            begin
                acc_we    = 1'b1;
                acc_waddr = dst_slot;
                acc_wdata = sum_sat;
            end
            default:
                ent_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[entry_count_reg[EA_W-1:0]] <= '{row: entry_row, col: entry_col,
                coeff: coeff, deno_fwd: deno_fwd, deno_rev: deno_rev};
        ent_rdata <= ent_mem[e_reg[EA_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (vec_we)
            vec_mem[vec_waddr] <= vec_wdata;
        vec_rdata <= vec_mem[vec_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
            acc_mem[acc_waddr] <= acc_wdata;
        acc_rdata <= acc_mem[acc_raddr];
    end

    // sequencer state, counters and sticky flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_INIT;
            entry_count_reg <= '0;
            e_reg           <= '0;
            clr_reg         <= '0;
            c_reg           <= '0;
            sat_reg         <= 1'b0;
            divz_reg        <= 1'b0;
            full_reg        <= 1'b0;
            rd_pend_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= accept && req_type == REQ_READ;
            if (state_reg == ST_INIT || state_reg == ST_CLEAR)
                clr_reg <= clr_reg + SLOT_W'(1);
            case (state_reg)
                ST_IDLE:
                    if (accept)
                    begin
                        case (req_type)
                            REQ_LOAD_ENTRY:
                                if (entry_count_reg == CNT_W'(MAX_ENTRIES))
                                    full_reg <= 1'b1;
                                else
                                    entry_count_reg <= entry_count_reg + CNT_W'(1);
                            REQ_COMPUTE:
                            begin
                                clr_reg  <= '0;
                                e_reg    <= '0;
                                sat_reg  <= 1'b0;
                                divz_reg <= 1'b0;
                            end
                            REQ_CLEAR:
                            begin
                                entry_count_reg <= '0;
                                full_reg        <= 1'b0;
                            end
                            default:
                                full_reg <= full_reg;
                        endcase
                    end
                ST_ENT_CHK:
                begin
                    c_reg <= '0;
                    if (ent_skip || ent_zero)
                        e_reg <= e_reg + CNT_W'(1);
                    if (!ent_skip && ent_zero)
                        divz_reg <= 1'b1;
                end
                ST_ACC_WR:
                begin
                    if (sum_ovf)
                        sat_reg <= 1'b1;
                    c_reg <= c_reg + 3'd1;
                    if (comp_last)
                        e_reg <= e_reg + CNT_W'(1);
                end
                default:
                    c_reg <= c_reg;
            endcase
        end
    end

    // entry operands and result capture
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ENT_CHK)
        begin
            src_reg <= cfg.direction ? ent_rdata.col : ent_rdata.row;
            dst_reg <= cfg.direction ? ent_rdata.row : ent_rdata.col;
            w_reg   <= $signed(ent_rdata.coeff);
            d_reg   <= $signed(ent_deno);
        end
        if (state_reg == ST_MUL)
            prod_reg <= w_reg * $signed(vec_rdata);
        slot_ok_reg  <= in_slot_ok;
        sat_out_reg  <= sat_reg;
        divz_out_reg <= divz_reg;
        full_out_reg <= full_reg;
    end

    assign done             = rd_pend_reg;
    assign result_value     = slot_ok_reg ? $signed(acc_rdata) : 32'sd0;
    assign saturated        = sat_out_reg;
    assign divided_by_zero  = divz_out_reg;
    assign store_overflowed = full_out_reg;

    // a result transaction only follows an accepted read
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && req_type == REQ_READ))
        else $error("result without a read");

    // a compute always holds the command side off
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == REQ_COMPUTE) |=> busy)
        else $error("compute not started");

    // entry count never passes the store depth
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(entry_count_reg) <= MAX_ENTRIES)
        else $error("entry count overrun");

    // walk index stays within the stored entries
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ENT_CHK) |-> (e_reg < entry_count_reg))
        else $error("entry walk past count");
endmodule
